// ===== hdl/ist_pkg.sv =====
// Shared types and codes for the integer set table.
// Used by every module of the block and by its checker; depends on nothing.
package ist_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;
  localparam int QUEUE_DEPTH = 2;

  // request operation codes
  localparam logic [1:0] FN_ADD      = 2'd0;
  localparam logic [1:0] FN_REMOVE   = 2'd1;
  localparam logic [1:0] FN_CONTAINS = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_total;
  } rsp_t;

  // operation after decode in the front end
  typedef enum logic [1:0] {
    K_ADD      = 2'd0,
    K_REMOVE   = 2'd1,
    K_CONTAINS = 2'd2,
    K_NOP      = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // one slot as held in the slot memory
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

endpackage

// ===== hdl/ist_front.sv =====
// Front end: takes request items, decodes the operation, holds one item
// until the command queue has room. Depends on ist_pkg.
module ist_front import ist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t request,
  output logic full,
  input  logic clearing,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);

  logic hold_valid;
  cmd_t hold;
  logic accept;
  op_kind_t kind;

  assign q_push = hold_valid && !q_full;
  assign q_cmd  = hold;
  assign full   = clearing || (hold_valid && q_full);
  assign accept = push && !full;

  always_comb begin
    case (request.func)
      FN_ADD:      kind = K_ADD;
      FN_REMOVE:   kind = K_REMOVE;
      FN_CONTAINS: kind = K_CONTAINS;
      default:     kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.kind  <= kind;
      hold.value <= request.value;
    end
  end

endmodule

// ===== hdl/ist_cmd_queue.sv =====
// Short command queue between the front end and the scan engine.
// Depends on ist_pkg.
module ist_cmd_queue import ist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// ===== hdl/ist_scan_engine.sv =====
// Back end: slot memory, linear scan for match and first free slot,
// update, occupancy count and the result register. Depends on ist_pkg.
module ist_scan_engine import ist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic clearing,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_LAST  = 6'b001000,
    S_APPLY = 6'b010000,
    S_REPLY = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  slot_t            mem [CAPACITY];
  slot_t            rd_data;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] addr;

  cmd_t             cur;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [1:0]       res_status;
  logic [COUNT_W-1:0] count;
  logic             out_valid;
  rsp_t             out_data;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             out_load;

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign result   = out_data;
  assign out_load = (state == S_REPLY) && (!out_valid || pop);

  // write port: clearing sweep, or the one update at the end of a scan
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_APPLY: begin
        if (cur.kind == K_ADD && !hit && free_found) begin
          wr_en         = 1'b1;
          wr_addr       = free_idx;
          wr_data.valid = 1'b1;
          wr_data.value = cur.value;
        end else if (cur.kind == K_REMOVE && hit) begin
          wr_en   = 1'b1;
          wr_addr = hit_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (addr == LAST_IDX) state_next = S_IDLE;
      S_IDLE:  if (!q_empty) state_next = S_SCAN;
      S_SCAN:  if (addr == LAST_IDX) state_next = S_LAST;
      S_LAST:  state_next = S_APPLY;
      S_APPLY: state_next = S_REPLY;
      S_REPLY: if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_SCAN) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      rd_valid  <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == S_SCAN);
      case (state)
        S_CLEAR, S_SCAN: addr <= (addr == LAST_IDX) ? '0 : addr + 1'b1;
        default:         addr <= '0;
      endcase
      if (state == S_APPLY) begin
        if (cur.kind == K_ADD && !hit && free_found) begin
          count <= count + 1'b1;
        end else if (cur.kind == K_REMOVE && hit) begin
          count <= count - 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (q_pop) begin
      cur        <= q_cmd;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_valid) begin
      if (rd_data.valid && rd_data.value == cur.value && !hit) begin
        hit     <= 1'b1;
        hit_idx <= rd_idx;
      end
      if (!rd_data.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    if (state == S_APPLY) begin
      case (cur.kind)
        K_ADD:      res_status <= hit ? ST_PRESENT : (free_found ? ST_DONE : ST_FULL);
        K_REMOVE:   res_status <= hit ? ST_DONE : ST_NOT_FOUND;
        K_CONTAINS: res_status <= hit ? ST_PRESENT : ST_NOT_FOUND;
        default:    res_status <= ST_DONE;
      endcase
    end
    if (out_load) begin
      out_data.status      <= res_status;
      out_data.entry_total <= count;
    end
  end

endmodule

// ===== hdl/integer_set_table.sv =====
// Top level of the integer set table: front end, command queue, scan engine.
// Depends on ist_pkg, ist_front, ist_cmd_queue and ist_scan_engine.
//
// A set of up to CAPACITY signed 32-bit values. Each request item carries
// func (add, remove, contains; code 3 does nothing) and a value, and gives
// exactly one result item: a status (done, present/found, not found, full)
// and entry_total, the number of occupied slots after the request, modulo
// 128. Add stores into the lowest free slot. In the scan engine each request
// goes through a start state, a scan that reads every slot in turn through a
// single read port, a state for the last read data, an update state and a
// state that loads the result. Requests are worked one at a time; the front
// end and a two-entry queue take up to three more while one is scanned. A
// finished result waits in its own register; a new result loads only when
// that register is free, and the engine holds in its reply state until then.
// After reset a clearing pass writes every slot empty, one a cycle; full
// stays high during it.
module integer_set_table import ist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t request,
  output logic full,
  output logic empty,
  input  logic pop,
  output rsp_t result
);

  logic clearing;
  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  // accept and decode
  ist_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // decouples decode from the scan
  ist_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // slot memory and linear scan
  ist_scan_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (q_out),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== hdl/ist_checker.sv =====
// Port-level checks for the integer set table, bound to the top level.
// Depends on ist_pkg and integer_set_table.
module ist_checker import ist_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input rsp_t result
);

  // nothing pending and the clearing pass running right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (empty && full))
    else $error("result or input open right after reset");

  // a waiting result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // full status only when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_FULL) |->
      (result.entry_total == COUNT_W'(CAPACITY)))
    else $error("full reported with free slots");

  // count never exceeds capacity when it fits the field
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && CAPACITY < 128) |-> (result.entry_total <= COUNT_W'(CAPACITY)))
    else $error("entry_total above capacity");

endmodule

bind integer_set_table ist_checker #(
  .CAPACITY (CAPACITY)
) u_ist_checker (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .result  (result)
);
